// ----- hdl/stb_pkg.sv -----
// Shared types and constants for the software timer bank.
package stb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int INDEX_WIDTH = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  timer_index;
        logic [15:0] reload_value;
    } req_beat_t;

    typedef struct packed {
        logic [3:0] expired_index;
        logic       last_event;
    } evt_beat_t;

    typedef struct packed {
        logic accept;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_blocked;
        logic scan_done;
    } ctrl_status_t;

endpackage

// ----- hdl/stb_ctrl.sv -----
// Sequencer that takes request beats and walks the timers on each tick.
module stb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           req_kind,
    output logic                 req_stall,
    input  stb_pkg::ctrl_status_t status,
    output stb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_kind == stb_pkg::KIND_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!status.emit_blocked)
                begin
                    cmd.step = 1'b1;
                    if (status.scan_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/stb_datapath.sv -----
// Timer counts, running flags, expiry mask and the event output register.
module stb_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stb_pkg::req_beat_t    req,
    input  stb_pkg::ctrl_cmd_t    cmd,
    output stb_pkg::ctrl_status_t status,
    output logic                  evt_valid,
    input  logic                  evt_stall,
    output stb_pkg::evt_beat_t    evt
);

    localparam int NT = stb_pkg::NUM_TIMERS;
    localparam int CW = stb_pkg::COUNT_WIDTH;
    localparam int IW = stb_pkg::INDEX_WIDTH;

    logic [CW-1:0]      count_reg [NT];
    logic [CW-1:0]      count_next [NT];
    logic [NT-1:0]      running_reg;
    logic [NT-1:0]      running_next;
    logic [NT-1:0]      mask_reg;
    logic [NT-1:0]      mask_next;
    logic [IW-1:0]      scan_index_reg;
    logic [IW-1:0]      scan_index_next;
    logic               evt_valid_reg;
    logic               evt_valid_next;
    stb_pkg::evt_beat_t evt_reg;
    stb_pkg::evt_beat_t evt_next;
    logic [IW-1:0]      sel;
    logic [CW-1:0]      reload;
    logic               sel_in_range;
    logic               emit;

    assign sel          = IW'(req.timer_index);
    assign reload       = CW'(req.reload_value);
    assign sel_in_range = (32'(req.timer_index) < NT);
    assign emit         = cmd.step && mask_reg[0];

    assign status.emit_blocked = mask_reg[0] && evt_valid_reg && evt_stall;
    assign status.scan_done    = (scan_index_reg == IW'(NT - 1));

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    always_comb
    begin
        count_next      = count_reg;
        running_next    = running_reg;
        mask_next       = mask_reg;
        scan_index_next = scan_index_reg;
        evt_next        = evt_reg;
        evt_valid_next  = evt_valid_reg && evt_stall;

        if (cmd.accept)
        begin
            scan_index_next = '0;
            if (req.kind == stb_pkg::KIND_START)
            begin
                if (sel_in_range && reload != '0)
                begin
                    count_next[sel]   = reload;
                    running_next[sel] = 1'b1;
                end
            end
            else if (req.kind == stb_pkg::KIND_STOP)
            begin
                if (sel_in_range)
                begin
                    running_next[sel] = 1'b0;
                end
            end
            else if (req.kind == stb_pkg::KIND_TICK)
            begin
                for (int i = 0; i < NT; i++)
                begin
                    mask_next[i] = running_reg[i] && (count_reg[i] == CW'(1));
                end
            end
        end

        if (cmd.step)
        begin
            if (running_reg[scan_index_reg])
            begin
                count_next[scan_index_reg] = count_reg[scan_index_reg] - CW'(1);
            end
            if (mask_reg[0])
            begin
                running_next[scan_index_reg] = 1'b0;
            end
            mask_next       = mask_reg >> 1;
            scan_index_next = scan_index_reg + IW'(1);
        end

        if (emit)
        begin
            evt_valid_next         = 1'b1;
            evt_next.expired_index = 4'(scan_index_reg);
            evt_next.last_event    = ((mask_reg >> 1) == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            mask_reg       <= '0;
            scan_index_reg <= '0;
            evt_valid_reg  <= 1'b0;
            for (int i = 0; i < NT; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            running_reg    <= running_next;
            mask_reg       <= mask_next;
            scan_index_reg <= scan_index_next;
            evt_valid_reg  <= evt_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

endmodule

// ----- hdl/software_timer_bank.sv -----
// Top level of the software timer bank.
// A bank of one-shot down-counting timers. Start and stop beats produce no events. A
// tick beat makes the sequencer walk the timers one per cycle through a single
// decrement path, except that the walk pauses while an expiry event waits because the
// output register still holds a stalled beat. Expiry events leave in ascending timer
// index, and the final one of a tick carries last_event. The request side is stalled
// while a tick is walked.
module software_timer_bank
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  stb_pkg::req_beat_t req,
    output logic               evt_valid,
    input  logic               evt_stall,
    output stb_pkg::evt_beat_t evt
);

    stb_pkg::ctrl_cmd_t    cmd;
    stb_pkg::ctrl_status_t status;

    stb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    stb_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

// ----- bench/software_timer_bank_tb.sv -----
// Self-checking testbench for the software timer bank with a timer scoreboard.
module software_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_EVENTS  = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 32;

    class timer_bank_scoreboard;
        logic [stb_pkg::COUNT_WIDTH-1:0] remaining [stb_pkg::NUM_TIMERS];
        bit                              running [stb_pkg::NUM_TIMERS];
        stb_pkg::evt_beat_t              pending_events [$];
        int                              mismatches;

        function new();
            for (int i = 0; i < stb_pkg::NUM_TIMERS; i++)
            begin
                remaining[i] = '0;
                running[i] = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void note_request(stb_pkg::req_beat_t beat);
            logic [stb_pkg::COUNT_WIDTH-1:0] loaded;
            stb_pkg::evt_beat_t held;
            bit have_held;
            int reported;
            loaded = stb_pkg::COUNT_WIDTH'(beat.reload_value);
            have_held = 1'b0;
            reported = 0;
            case (beat.kind)
                stb_pkg::KIND_START:
                begin
                    if (int'(beat.timer_index) < stb_pkg::NUM_TIMERS && loaded != '0)
                    begin
                        remaining[beat.timer_index] = loaded;
                        running[beat.timer_index] = 1'b1;
                    end
                end
                stb_pkg::KIND_STOP:
                begin
                    if (int'(beat.timer_index) < stb_pkg::NUM_TIMERS)
                        running[beat.timer_index] = 1'b0;
                end
                stb_pkg::KIND_TICK:
                begin
                    for (int i = 0; i < stb_pkg::NUM_TIMERS; i++)
                    begin
                        if (running[i])
                        begin
                            remaining[i] = remaining[i] - 1'b1;
                            if (remaining[i] == '0)
                            begin
                                running[i] = 1'b0;
                                if (reported < MAX_EVENTS)
                                begin
                                    if (have_held)
                                        pending_events.push_back(held);
                                    held.expired_index = i[3:0];
                                    held.last_event = 1'b0;
                                    have_held = 1'b1;
                                    reported++;
                                end
                            end
                        end
                    end
                    if (have_held)
                    begin
                        held.last_event = 1'b1;
                        pending_events.push_back(held);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string what);
            if (mismatches < 50)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_event(stb_pkg::evt_beat_t got);
            stb_pkg::evt_beat_t want;
            if (pending_events.size() == 0)
            begin
                report($sformatf("unexpected expiry of timer %0d", got.expired_index));
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.expired_index !== want.expired_index)
                    report($sformatf("expired_index %0d, wanted %0d",
                                     got.expired_index, want.expired_index));
                if (got.last_event !== want.last_event)
                    report($sformatf("last_event %b on timer %0d, wanted %b",
                                     got.last_event, want.expired_index, want.last_event));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    stb_pkg::req_beat_t req = '0;
    logic               evt_valid;
    logic               evt_stall = 1'b0;
    stb_pkg::evt_beat_t evt;

    timer_bank_scoreboard book;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    software_timer_bank dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_valid && !evt_stall)
                book.check_event(evt);
            evt_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (evt_valid && !evt_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("software_timer_bank_tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic [1:0] kind, input logic [3:0] index,
                             input logic [15:0] reload);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{kind: kind, timer_index: index, reload_value: reload};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        book.note_request(req);
    endtask

    task automatic send_random(input int count);
        int done;
        int choice;
        done = 0;
        while (done < count)
        begin
            choice = $urandom_range(99);
            if (choice < 8)
            begin
                for (int i = 0; i < stb_pkg::NUM_TIMERS; i++)
                    send_beat(stb_pkg::KIND_START, i[3:0], 16'($urandom_range(1, 3)));
                repeat (3)
                    send_beat(stb_pkg::KIND_TICK, 4'($urandom()), 16'($urandom()));
                done += stb_pkg::NUM_TIMERS + 3;
            end
            else if (choice < 45)
            begin
                send_beat(stb_pkg::KIND_TICK, 4'($urandom()), 16'($urandom()));
                done++;
            end
            else if (choice < 80)
            begin
                send_beat(stb_pkg::KIND_START, 4'($urandom()),
                          ($urandom_range(3) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(1, 12)));
                done++;
            end
            else if (choice < 93)
            begin
                send_beat(stb_pkg::KIND_STOP, 4'($urandom()), 16'($urandom()));
                done++;
            end
            else if (choice < 97)
            begin
                send_beat(KIND_UNUSED, 4'($urandom()), 16'($urandom()));
                done++;
            end
            else
            begin
                send_beat(stb_pkg::KIND_START, 4'($urandom()), 16'h0000);
                done++;
            end
        end
    endtask

    initial
    begin
        book = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(stb_pkg::KIND_TICK, 4'd0, 16'h0000);
        send_beat(stb_pkg::KIND_START, 4'd0, 16'h0001);
        send_beat(stb_pkg::KIND_START, 4'd15, 16'h0002);
        send_beat(stb_pkg::KIND_START, 4'd3, 16'h0000);
        send_beat(KIND_UNUSED, 4'd3, 16'hFFFF);
        send_beat(stb_pkg::KIND_STOP, 4'd7, 16'h0000);
        send_beat(stb_pkg::KIND_TICK, 4'd15, 16'hFFFF);
        send_beat(stb_pkg::KIND_START, 4'd15, 16'h0003);
        repeat (3)
            send_beat(stb_pkg::KIND_TICK, 4'd0, 16'h0000);
        send_beat(stb_pkg::KIND_START, 4'd5, 16'hFFFF);
        send_beat(stb_pkg::KIND_STOP, 4'd5, 16'h0000);
        send_beat(stb_pkg::KIND_TICK, 4'd0, 16'h0000);
        send_beat(stb_pkg::KIND_START, 4'd5, 16'h0001);
        send_beat(stb_pkg::KIND_START, 4'd10, 16'h0001);
        send_beat(stb_pkg::KIND_START, 4'd2, 16'h0001);
        send_beat(stb_pkg::KIND_TICK, 4'd0, 16'h0000);
        send_beat(stb_pkg::KIND_STOP, 4'd2, 16'h0000);
        send_beat(stb_pkg::KIND_TICK, 4'd0, 16'h0000);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 66;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 66;
                end
                default:
                begin
                    idle_pct = 33;
                    stall_pct = 33;
                end
            endcase
            send_random(PHASE_ITEMS);
        end
        req_valid <= 1'b0;

        while (book.pending_events.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        if (book.mismatches == 0 && book.pending_events.size() == 0)
        begin
            $display("software_timer_bank_tb: PASS");
        end
        else
        begin
            $display("software_timer_bank_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- software_timer_bank.f -----
hdl/stb_pkg.sv
hdl/stb_ctrl.sv
hdl/stb_datapath.sv
hdl/software_timer_bank.sv
bench/software_timer_bank_tb.sv
